/* rtl/core/energy_voice_segmenter_macros.svh */
// ----------------------------------------------------------------------------
// energy_voice_segmenter_macros
// Assertion macros used by the segmenter frame core.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_SEGMENTER_MACROS_SVH
`define ENERGY_VOICE_SEGMENTER_MACROS_SVH

`ifndef SYNTHESIS
`define EVS_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("evs assertion failed");
`define EVS_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("evs assertion failed");
`else
`define EVS_ASSERT_IMP(label, ck, rn, ante, cons)
`define EVS_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

/* rtl/core/evs_pkg.sv */
// ----------------------------------------------------------------------------
// evs_pkg
// Types and constants of the energy voice segmenter.
// ----------------------------------------------------------------------------
package evs_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FRAMES   = 2'd2;

  localparam logic [31:0] RST_LOUD_THR     = 32'd100000;
  localparam logic [3:0]  RST_START_FRAMES = 4'd5;
  localparam logic [3:0]  RST_END_FRAMES   = 4'd5;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_STARTING = 2'd1,
    PH_ACTIVE   = 2'd2,
    PH_ENDING   = 2'd3
  } evs_phase_t;

  typedef struct packed {
    logic [31:0] loud_thr;
    logic [3:0]  start_frames;
    logic [3:0]  end_frames;
  } evs_cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frame_last;
  } evs_item_t;

endpackage

/* rtl/core/evs_in_if.sv */
// ----------------------------------------------------------------------------
// evs_in_if
// Sample input channel: valid/ready with one sample and frame-last flag.
// ----------------------------------------------------------------------------
interface evs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_last;

  modport source (output valid, output sample, output frame_last, input ready);
  modport sink   (input valid, input sample, input frame_last, output ready);
endinterface

/* rtl/core/evs_out_if.sv */
// ----------------------------------------------------------------------------
// evs_out_if
// Frame decision channel: valid/ready with one decision per frame.
// ----------------------------------------------------------------------------
interface evs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  new_phase;
  logic        keep_frame;
  logic        discard_segment;
  logic        segment_done;
  logic [19:0] segment_samples;
  logic [31:0] frame_energy;
  logic        overflow;

  modport source (output valid, output new_phase, output keep_frame,
                  output discard_segment, output segment_done,
                  output segment_samples, output frame_energy, output overflow,
                  input ready);
  modport sink   (input valid, input new_phase, input keep_frame,
                  input discard_segment, input segment_done,
                  input segment_samples, input frame_energy, input overflow,
                  output ready);
endinterface

/* rtl/core/evs_cfg_if.sv */
// ----------------------------------------------------------------------------
// evs_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface evs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [evs_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/energy_voice_segmenter.sv */
// ----------------------------------------------------------------------------
// energy_voice_segmenter
// Energy-based voice activity detector with hangover, one decision per frame.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while input ready is high. Samples pass through an input
// register into the frame core, which sums absolute values and, on the
// frame-last sample, runs the idle/starting/active/ending machine and loads
// the result register; the registered decision is valid in the cycle after
// the core takes the frame-last sample. Samples that are not frame-last
// produce no result. Input ready drops only while a frame-last sample waits
// behind an unread result.
// Configuration writes are accepted every cycle and must be made while idle.
module energy_voice_segmenter #(
  parameter int unsigned MAX_SEGMENT_SAMPLES = 524288
) (
  input  logic      clk,
  input  logic      rst_n,
  evs_in_if.sink    in_ch,
  evs_out_if.source out_ch,
  evs_cfg_if.sink   cfg_ch
);
  import evs_pkg::*;

  evs_cfg_t  cfg;
  logic      s1_valid;
  evs_item_t s1_item;
  logic      s1_take;

  evs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  evs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  evs_frame_core #(
    .MAX_SEGMENT_SAMPLES (MAX_SEGMENT_SAMPLES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

endmodule

/* rtl/core/evs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// evs_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module evs_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  evs_cfg_if.sink           cfg_ch,
  output evs_pkg::evs_cfg_t cfg
);
  import evs_pkg::*;

  evs_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loud_thr     <= RST_LOUD_THR;
      cfg_r.start_frames <= RST_START_FRAMES;
      cfg_r.end_frames   <= RST_END_FRAMES;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LOUD_THR:     cfg_r.loud_thr     <= cfg_ch.data;
        CFG_START_FRAMES: cfg_r.start_frames <= cfg_ch.data[3:0];
        CFG_END_FRAMES:   cfg_r.end_frames   <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/evs_in_stage.sv */
// ----------------------------------------------------------------------------
// evs_in_stage
// Input register: holds one accepted sample until the frame core takes it.
// ----------------------------------------------------------------------------
module evs_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  evs_in_if.sink             in_ch,
  output logic               s1_valid,
  output evs_pkg::evs_item_t s1_item,
  input  logic               s1_take
);
  import evs_pkg::*;

  logic      s1_valid_r;
  evs_item_t s1_item_r;

  assign in_ch.ready = !s1_valid_r || s1_take;
  assign s1_valid    = s1_valid_r;
  assign s1_item     = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.sample     <= in_ch.sample;
      s1_item_r.frame_last <= in_ch.frame_last;
    end
  end

endmodule

/* rtl/core/evs_frame_core.sv */
// ----------------------------------------------------------------------------
// evs_frame_core
// Energy accumulation, frame state machine and result register.
// ----------------------------------------------------------------------------
`include "energy_voice_segmenter_macros.svh"

module evs_frame_core #(
  parameter int unsigned MAX_SEGMENT_SAMPLES = 524288
) (
  input  logic               clk,
  input  logic               rst_n,
  input  evs_pkg::evs_cfg_t  cfg,
  input  logic               s1_valid,
  input  evs_pkg::evs_item_t s1_item,
  output logic               s1_take,
  evs_out_if.source          out_ch
);
  import evs_pkg::*;

  localparam int unsigned     LEN_W   = $clog2(MAX_SEGMENT_SAMPLES + 2);
  localparam logic [LEN_W-1:0] CNT_SAT = LEN_W'(MAX_SEGMENT_SAMPLES + 1);
  localparam logic [LEN_W:0]   SEG_MAX = (LEN_W + 1)'(MAX_SEGMENT_SAMPLES);

  logic [31:0]      energy_r;
  logic [LEN_W-1:0] fcnt_r;
  evs_phase_t       phase_r, phase_nxt;
  logic [4:0]       start_cnt_r, start_cnt_nxt;
  logic [4:0]       end_cnt_r, end_cnt_nxt;
  logic [LEN_W-1:0] seg_len_r, seg_len_nxt;

  logic             out_valid_r;
  evs_phase_t       out_phase_r;
  logic             out_keep_r;
  logic             out_discard_r;
  logic             out_done_r;
  logic [19:0]      out_seg_r;
  logic [31:0]      out_energy_r;
  logic             out_ovf_r;

  logic             out_free;
  logic             fire_last;
  logic [16:0]      mag;
  logic [32:0]      acc_sum;
  logic [31:0]      energy_sum;
  logic [LEN_W-1:0] fcnt_sum;
  logic             loud;
  logic [LEN_W:0]   app_sum;
  logic             app_clip;
  logic [LEN_W-1:0] app_len;
  logic [4:0]       start_inc;
  logic [4:0]       end_inc;
  logic [4:0]       end_dec;
  logic             keep;
  logic             discard;
  logic             done;
  logic             ovf;
  logic [LEN_W-1:0] report_len;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_take   = s1_valid && (!s1_item.frame_last || out_free);
  assign fire_last = s1_take && s1_item.frame_last;

  // datapath
  assign mag        = s1_item.sample[15] ? (17'h10000 - {1'b0, s1_item.sample})
                                         : {1'b0, s1_item.sample};
  assign acc_sum    = {1'b0, energy_r} + {16'b0, mag};
  assign energy_sum = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign fcnt_sum   = (fcnt_r == CNT_SAT) ? CNT_SAT : fcnt_r + LEN_W'(1);
  assign loud       = energy_sum >= cfg.loud_thr;
  assign app_sum    = {1'b0, seg_len_r} + {1'b0, fcnt_sum};
  assign app_clip   = app_sum > SEG_MAX;
  assign app_len    = app_clip ? SEG_MAX[LEN_W-1:0] : app_sum[LEN_W-1:0];
  assign start_inc  = start_cnt_r + 5'd1;
  assign end_inc    = end_cnt_r + 5'd1;
  assign end_dec    = (end_cnt_r != 5'd0) ? end_cnt_r - 5'd1 : 5'd0;

  // state machine outputs
  always_comb begin
    keep       = loud || (phase_r == PH_ACTIVE) || (phase_r == PH_ENDING);
    discard    = !loud && (phase_r == PH_STARTING);
    done       = !loud && (phase_r == PH_ENDING) && (end_inc > {1'b0, cfg.end_frames});
    ovf        = keep && app_clip;
    report_len = discard ? '0 : (keep ? app_len : seg_len_r);
  end

  // state machine next state
  always_comb begin
    phase_nxt     = phase_r;
    start_cnt_nxt = start_cnt_r;
    end_cnt_nxt   = end_cnt_r;
    case (phase_r)
      PH_IDLE: begin
        if (loud) begin
          phase_nxt     = PH_STARTING;
          start_cnt_nxt = start_inc;
        end
      end
      PH_STARTING: begin
        if (loud) begin
          start_cnt_nxt = start_inc;
          if (start_inc > {1'b0, cfg.start_frames}) begin
            phase_nxt = PH_ACTIVE;
          end
        end else begin
          phase_nxt     = PH_IDLE;
          start_cnt_nxt = 5'd0;
        end
      end
      PH_ACTIVE: begin
        if (!loud) begin
          phase_nxt   = PH_ENDING;
          end_cnt_nxt = end_inc;
        end
      end
      PH_ENDING: begin
        if (loud) begin
          end_cnt_nxt = end_dec;
          if (end_dec == 5'd0) begin
            phase_nxt = PH_ACTIVE;
          end
        end else if (done) begin
          phase_nxt     = PH_IDLE;
          end_cnt_nxt   = 5'd0;
          start_cnt_nxt = 5'd0;
        end else begin
          end_cnt_nxt = end_inc;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    if (done || discard) begin
      seg_len_nxt = '0;
    end else if (keep) begin
      seg_len_nxt = app_len;
    end else begin
      seg_len_nxt = seg_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r    <= '0;
      fcnt_r      <= '0;
      phase_r     <= PH_IDLE;
      start_cnt_r <= '0;
      end_cnt_r   <= '0;
      seg_len_r   <= '0;
    end else if (fire_last) begin
      energy_r    <= '0;
      fcnt_r      <= '0;
      phase_r     <= phase_nxt;
      start_cnt_r <= start_cnt_nxt;
      end_cnt_r   <= end_cnt_nxt;
      seg_len_r   <= seg_len_nxt;
    end else if (s1_take) begin
      energy_r <= energy_sum;
      fcnt_r   <= fcnt_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      out_phase_r   <= phase_nxt;
      out_keep_r    <= keep;
      out_discard_r <= discard;
      out_done_r    <= done;
      out_seg_r     <= 20'(report_len);
      out_energy_r  <= energy_sum;
      out_ovf_r     <= ovf;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.new_phase       = out_phase_r;
  assign out_ch.keep_frame      = out_keep_r;
  assign out_ch.discard_segment = out_discard_r;
  assign out_ch.segment_done    = out_done_r;
  assign out_ch.segment_samples = out_seg_r;
  assign out_ch.frame_energy    = out_energy_r;
  assign out_ch.overflow        = out_ovf_r;

  `EVS_ASSERT_NXT(a_last_gives_result, clk, rst_n, fire_last, out_valid_r)
  `EVS_ASSERT_IMP(a_seg_bounded, clk, rst_n, 1'b1, {1'b0, seg_len_r} <= SEG_MAX)
  `EVS_ASSERT_IMP(a_idle_clean, clk, rst_n, phase_r == PH_IDLE,
                  (start_cnt_r == 5'd0) && (seg_len_r == '0))
  `EVS_ASSERT_IMP(a_close_to_idle, clk, rst_n,
                  out_valid_r && (out_discard_r || out_done_r),
                  (out_phase_r == PH_IDLE) && !(out_discard_r && out_done_r))

endmodule
